### hdl/irb_pkg.sv
package irb_pkg;

   // Command codes carried in the cmd field of an input beat.
   localparam logic [1:0] CMD_WRITE_BLOCK = 2'd0;
   localparam logic [1:0] CMD_WRITE_ALLOW = 2'd1;
   localparam logic [1:0] CMD_QUERY       = 2'd2;
   localparam logic [1:0] CMD_RESERVED    = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BLOCK_COUNT = 2'd0;
   localparam logic [1:0] CSR_ALLOW_COUNT = 2'd1;
   localparam logic [1:0] CSR_BLOCK_HTTP  = 2'd2;

   localparam int CSR_DATA_BITS = 13;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] entry_index;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic [15:0] label_id;
      logic [31:0] query_address;
      logic        port_allowed;
   } req_type;

   typedef struct packed {
      logic        blocked;
      logic [15:0] match_label;
      logic        block_hit;
      logic        allow_hit;
   } rsp_type;

   typedef struct packed {
      logic [12:0] block_count;
      logic [10:0] allow_count;
      logic        block_http;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_LOAD_BLOCK,
      OP_LOAD_ALLOW,
      OP_QUERY
   } op_type;

   // Classified work item passed from the front end to the search engine.
   // For a query the address travels in the start field.
   typedef struct packed {
      op_type      op;
      logic [11:0] index;
      logic [31:0] start;
      logic [31:0] stop;
      logic [15:0] label;
      logic        exempt;
   } work_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE_RD,
      ST_PROBE_CMP,
      ST_RESOLVE,
      ST_FIRST_CMP,
      ST_FINAL_RD,
      ST_FINAL_CMP,
      ST_DONE
   } search_state_type;

endpackage

### hdl/irb_front.sv
module irb_front #(
   parameter int BLOCK_DEPTH = 4096,
   parameter int ALLOW_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  irb_pkg::req_type  req_data,
   output irb_pkg::work_type item,
   output logic              item_valid,
   input  logic              item_pop
);

   irb_pkg::work_type q_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       keep;
   logic       push_ok;
   logic       pop_ok;
   logic [31:0] widx;
   irb_pkg::work_type new_item;

   assign widx = 32'(req_data.entry_index);

   // Loads outside a table and unknown commands are dropped here.
   always_comb begin
      keep = 1'b0;
      new_item.op     = irb_pkg::OP_QUERY;
      new_item.index  = req_data.entry_index;
      new_item.start  = req_data.range_start;
      new_item.stop   = req_data.range_end;
      new_item.label  = req_data.label_id;
      new_item.exempt = req_data.port_allowed;
      unique case (req_data.cmd)
         irb_pkg::CMD_WRITE_BLOCK: begin
            new_item.op = irb_pkg::OP_LOAD_BLOCK;
            keep = (widx < 32'(BLOCK_DEPTH));
         end
         irb_pkg::CMD_WRITE_ALLOW: begin
            new_item.op = irb_pkg::OP_LOAD_ALLOW;
            keep = (widx < 32'(ALLOW_DEPTH));
         end
         irb_pkg::CMD_QUERY: begin
            new_item.op    = irb_pkg::OP_QUERY;
            new_item.start = req_data.query_address;
            keep = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];
   assign push_ok    = req_push && !req_full && keep;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      wp_in  = push_ok ? ~wp_ff : wp_ff;
      rp_in  = pop_ok ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wp_ff] <= new_item;
      end
   end

endmodule

### hdl/irb_engine.sv
module irb_engine #(
   parameter int BLOCK_DEPTH = 4096,
   parameter int ALLOW_DEPTH = 1024,
   parameter int LABEL_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  irb_pkg::cfg_type  cfg,
   input  irb_pkg::work_type item,
   input  logic              item_valid,
   output logic              item_pop,
   output irb_pkg::rsp_type  rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   localparam int BAW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
   localparam int AAW = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
   localparam int MAW = (BAW > AAW) ? BAW : AAW;
   localparam int CW  = (MAW + 1 > 13) ? MAW + 1 : 13;
   localparam logic [CW-1:0] BDEP = CW'(BLOCK_DEPTH);
   localparam logic [CW-1:0] ADEP = CW'(ALLOW_DEPTH);

   logic [31:0]           b_starts [BLOCK_DEPTH];
   logic [31:0]           b_ends   [BLOCK_DEPTH];
   logic [LABEL_BITS-1:0] b_labels [BLOCK_DEPTH];
   logic [31:0]           a_starts [ALLOW_DEPTH];
   logic [31:0]           a_ends   [ALLOW_DEPTH];

   logic [31:0]           b_start_rd, b_end_rd, a_start_rd, a_end_rd;
   logic [LABEL_BITS-1:0] b_label_rd;

   irb_pkg::search_state_type state_ff, state_in;
   logic [CW-1:0] first_ff, first_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          tbl_ff, tbl_in;
   logic          bhit_ff, bhit_in;
   logic          ahit_ff, ahit_in;
   logic [LABEL_BITS-1:0] label_ff, label_in;
   logic [31:0]   addr_ff, addr_in;
   logic          exempt_ff, exempt_in;
   irb_pkg::rsp_type out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   logic [CW-1:0] half, mid, sidx, blk_n, alw_n;
   logic [31:0]   cur_start, cur_end, widx, lbl_wide, lbl_out;
   logic          bwe, awe, tbl_done, tbl_hit;

   assign widx  = 32'(item.index);
   assign lbl_wide = 32'(item.label);
   assign half  = n_ff >> 1;
   assign mid   = first_ff + half;
   assign blk_n = (CW'(cfg.block_count) > BDEP) ? BDEP : CW'(cfg.block_count);
   assign alw_n = (CW'(cfg.allow_count) > ADEP) ? ADEP : CW'(cfg.allow_count);
   assign cur_start = tbl_ff ? a_start_rd : b_start_rd;
   assign cur_end   = tbl_ff ? a_end_rd : b_end_rd;

   always_comb begin
      lbl_out = '0;
      lbl_out[LABEL_BITS-1:0] = label_ff;
   end

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      n_in         = n_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      tbl_in       = tbl_ff;
      bhit_in      = bhit_ff;
      ahit_in      = ahit_ff;
      label_in     = label_ff;
      addr_in      = addr_ff;
      exempt_in    = exempt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      item_pop     = 1'b0;
      bwe          = 1'b0;
      awe          = 1'b0;
      sidx         = mid;
      tbl_done     = 1'b0;
      tbl_hit      = 1'b0;
      unique case (state_ff)
         irb_pkg::ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               unique case (item.op)
                  irb_pkg::OP_LOAD_BLOCK: bwe = 1'b1;
                  irb_pkg::OP_LOAD_ALLOW: awe = 1'b1;
                  irb_pkg::OP_QUERY: begin
                     addr_in   = item.start;
                     exempt_in = item.exempt;
                     tbl_in    = 1'b0;
                     first_in  = '0;
                     n_in      = blk_n;
                     limit_in  = blk_n;
                     state_in  = (blk_n != '0) ? irb_pkg::ST_PROBE_RD
                                               : irb_pkg::ST_RESOLVE;
                  end
                  default: ;
               endcase
            end
         end
         irb_pkg::ST_PROBE_RD: begin
            sidx     = mid;
            state_in = irb_pkg::ST_PROBE_CMP;
         end
         irb_pkg::ST_PROBE_CMP: begin
            if (cur_start < addr_ff) begin
               first_in = mid + CW'(1);
               n_in     = n_ff - half - CW'(1);
            end else begin
               n_in     = half;
            end
            state_in = (n_in != '0) ? irb_pkg::ST_PROBE_RD : irb_pkg::ST_RESOLVE;
         end
         irb_pkg::ST_RESOLVE: begin
            sidx = first_ff;
            if (first_ff == limit_ff) begin
               if (first_ff == '0) begin
                  tbl_done = 1'b1;
               end else begin
                  idx_in   = first_ff - CW'(1);
                  state_in = irb_pkg::ST_FINAL_RD;
               end
            end else begin
               state_in = irb_pkg::ST_FIRST_CMP;
            end
         end
         irb_pkg::ST_FIRST_CMP: begin
            if (cur_start == addr_ff) begin
               idx_in   = first_ff;
               state_in = irb_pkg::ST_FINAL_RD;
            end else if (first_ff == '0) begin
               tbl_done = 1'b1;
            end else begin
               idx_in   = first_ff - CW'(1);
               state_in = irb_pkg::ST_FINAL_RD;
            end
         end
         irb_pkg::ST_FINAL_RD: begin
            sidx     = idx_ff;
            state_in = irb_pkg::ST_FINAL_CMP;
         end
         irb_pkg::ST_FINAL_CMP: begin
            tbl_done = 1'b1;
            tbl_hit  = (cur_start <= addr_ff) && (addr_ff <= cur_end);
         end
         irb_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_in.blocked     = bhit_ff && !ahit_ff &&
                                    !(!cfg.block_http && exempt_ff);
               out_in.match_label = bhit_ff ? lbl_out[15:0] : 16'd0;
               out_in.block_hit   = bhit_ff;
               out_in.allow_hit   = ahit_ff;
               out_valid_in       = 1'b1;
               state_in           = irb_pkg::ST_IDLE;
            end
         end
         default: state_in = irb_pkg::ST_IDLE;
      endcase

      // End of one table's search: move on to the allow table, or finish.
      if (tbl_done) begin
         if (!tbl_ff) begin
            bhit_in  = tbl_hit;
            label_in = b_label_rd;
            tbl_in   = 1'b1;
            first_in = '0;
            n_in     = alw_n;
            limit_in = alw_n;
            state_in = (alw_n != '0) ? irb_pkg::ST_PROBE_RD : irb_pkg::ST_RESOLVE;
         end else begin
            ahit_in  = tbl_hit;
            state_in = irb_pkg::ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irb_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      n_ff      <= n_in;
      limit_ff  <= limit_in;
      idx_ff    <= idx_in;
      tbl_ff    <= tbl_in;
      bhit_ff   <= bhit_in;
      ahit_ff   <= ahit_in;
      label_ff  <= label_in;
      addr_ff   <= addr_in;
      exempt_ff <= exempt_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (bwe) begin
         b_starts[widx[BAW-1:0]] <= item.start;
         b_ends[widx[BAW-1:0]]   <= item.stop;
         b_labels[widx[BAW-1:0]] <= lbl_wide[LABEL_BITS-1:0];
      end
      b_start_rd <= b_starts[sidx[BAW-1:0]];
      b_end_rd   <= b_ends[sidx[BAW-1:0]];
      b_label_rd <= b_labels[sidx[BAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (awe) begin
         a_starts[widx[AAW-1:0]] <= item.start;
         a_ends[widx[AAW-1:0]]   <= item.stop;
      end
      a_start_rd <= a_starts[sidx[AAW-1:0]];
      a_end_rd   <= a_ends[sidx[AAW-1:0]];
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;

endmodule

### hdl/ip_range_block_allow_lookup_top.sv
// IPv4 range block/allow lookup.
// Input beats enter through a queue-style port: a beat is taken on a rising
// edge with req_push high and req_full low. A beat either loads one entry of
// the block table or of the allow table, or asks whether an address is
// blocked. Loads give no result; each query gives exactly one result beat.
// Results leave through a queue-style port: the oldest result is shown while
// rsp_empty is low and is taken on an edge with rsp_pop high.
// A two-entry front queue takes beats while the search engine is busy, and a
// result register holds a finished answer, so a stalled receiver only halts
// the engine once a second answer is ready; beats keep being queued until
// the front queue fills.
// A load is taken and written from the idle state. A query runs two binary
// searches on one read port per table, each probe a read and then a compare,
// with ceil(log2(count+1)) probes per table; the engine then resolves the
// landing entry and checks its range, first for the block table and then
// for the allow table, and delivers the answer to the result register.
// Reset empties both queues, sets block_count and allow_count to zero and
// block_http to one. Table contents are not cleared and must be loaded
// before the counts cover them. Configuration is written while idle by the user; the block does not enforce it.
module ip_range_block_allow_lookup_top #(
   parameter int BLOCK_DEPTH = 4096,
   parameter int ALLOW_DEPTH = 1024,
   parameter int LABEL_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  irb_pkg::req_type                    req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output irb_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_en,
   input  logic [1:0]                          csr_index,
   input  logic [irb_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   irb_pkg::cfg_type  cfg_ff, cfg_in;
   irb_pkg::work_type item;
   logic              item_valid;
   logic              item_pop;

   // Writes to indexes beyond the register list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            irb_pkg::CSR_BLOCK_COUNT: cfg_in.block_count = csr_wdata[12:0];
            irb_pkg::CSR_ALLOW_COUNT: cfg_in.allow_count = csr_wdata[10:0];
            irb_pkg::CSR_BLOCK_HTTP:  cfg_in.block_http  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_count <= '0;
         cfg_ff.allow_count <= '0;
         cfg_ff.block_http  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   irb_front #(
      .BLOCK_DEPTH(BLOCK_DEPTH),
      .ALLOW_DEPTH(ALLOW_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   irb_engine #(
      .BLOCK_DEPTH(BLOCK_DEPTH),
      .ALLOW_DEPTH(ALLOW_DEPTH),
      .LABEL_BITS (LABEL_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

endmodule

### hdl/irb_checker.sv
module irb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input irb_pkg::rsp_type rsp_data
);

   // Nothing is queued straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A waiting result beat holds until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result beat changed while stalled");

   a_blocked_hit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.blocked) |-> (rsp_data.block_hit && !rsp_data.allow_hit))
      else $error("blocked without a block hit or despite an allow hit");

   a_label_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.block_hit) |-> (rsp_data.match_label == 16'd0))
      else $error("label given without a block hit");

endmodule

bind ip_range_block_allow_lookup_top irb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

### tb/sv/irb_lookup_checker.sv
// Watches the three ports of the lookup block, keeps its own copy of both
// range tables and of the registers, and checks every result beat in order.
module irb_lookup_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  logic                               req_full,
   input  irb_pkg::req_type                   req_data,
   input  logic                               rsp_empty,
   input  logic                               rsp_pop,
   input  irb_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [1:0]                         csr_index,
   input  logic [irb_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 pending_verdicts,
   output int                                 mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLK_ROWS = 4096;
   localparam int ALW_ROWS = 1024;

   logic [31:0]      blk_lo [BLK_ROWS];
   logic [31:0]      blk_hi [BLK_ROWS];
   logic [15:0]      blk_tag [BLK_ROWS];
   logic [31:0]      alw_lo [ALW_ROWS];
   logic [31:0]      alw_hi [ALW_ROWS];
   logic [12:0]      blk_cnt;
   logic [10:0]      alw_cnt;
   logic             http_on;
   irb_pkg::rsp_type verdict_q[$];

   function automatic logic [31:0] lo_at(input bit in_blk, input int pos);
      return in_blk ? blk_lo[pos] : alw_lo[pos];
   endfunction

   // Lower-bound search for the last range starting at or below addr, then
   // a check of that one range.
   function automatic bit find_range(input bit in_blk, input logic [31:0] addr,
                                     output int hit_pos);
      int first, n, lim, half, mid, idx;
      first   = 0;
      hit_pos = 0;
      if (in_blk) n = (blk_cnt > BLK_ROWS) ? BLK_ROWS : int'(blk_cnt);
      else n = (alw_cnt > ALW_ROWS) ? ALW_ROWS : int'(alw_cnt);
      lim = n;
      while (n > 0) begin
         half = n >> 1;
         mid  = first + half;
         if (lo_at(in_blk, mid) < addr) begin
            first = mid + 1;
            n     = n - (half + 1);
         end else begin
            n = half;
         end
      end
      if (first == lim || lo_at(in_blk, first) != addr) begin
         if (first == 0) return 0;
         idx = first - 1;
      end else begin
         idx = first;
      end
      if (lo_at(in_blk, idx) <= addr &&
          addr <= (in_blk ? blk_hi[idx] : alw_hi[idx])) begin
         hit_pos = idx;
         return 1;
      end
      return 0;
   endfunction

   function automatic irb_pkg::rsp_type lookup_verdict(input irb_pkg::req_type q);
      irb_pkg::rsp_type v;
      int               bpos, apos;
      v.block_hit   = find_range(1'b1, q.query_address, bpos);
      v.allow_hit   = find_range(1'b0, q.query_address, apos);
      v.match_label = v.block_hit ? blk_tag[bpos] : 16'd0;
      v.blocked     = v.block_hit && !v.allow_hit && !(!http_on && q.port_allowed);
      return v;
   endfunction

   task automatic report(input string field, input int exp_val, input int act_val);
      $display("%0t: mismatch in %s, expected %0d, actual %0d",
               $time, field, exp_val, act_val);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      irb_pkg::rsp_type want;
      if (reset) begin
         blk_cnt = '0;
         alw_cnt = '0;
         http_on = 1'b1;
         verdict_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               irb_pkg::CSR_BLOCK_COUNT: blk_cnt = csr_wdata[12:0];
               irb_pkg::CSR_ALLOW_COUNT: alw_cnt = csr_wdata[10:0];
               irb_pkg::CSR_BLOCK_HTTP:  http_on = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            case (req_data.cmd)
               irb_pkg::CMD_WRITE_BLOCK: begin
                  blk_lo[req_data.entry_index]  = req_data.range_start;
                  blk_hi[req_data.entry_index]  = req_data.range_end;
                  blk_tag[req_data.entry_index] = req_data.label_id;
               end
               irb_pkg::CMD_WRITE_ALLOW: begin
                  if (req_data.entry_index < ALW_ROWS) begin
                     alw_lo[req_data.entry_index] = req_data.range_start;
                     alw_hi[req_data.entry_index] = req_data.range_end;
                  end
               end
               irb_pkg::CMD_QUERY: verdict_q = {verdict_q, lookup_verdict(req_data)};
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: result beat with none expected, actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.blocked !== want.blocked)
                  report("blocked", want.blocked, rsp_data.blocked);
               if (rsp_data.match_label !== want.match_label)
                  report("match_label", want.match_label, rsp_data.match_label);
               if (rsp_data.block_hit !== want.block_hit)
                  report("block_hit", want.block_hit, rsp_data.block_hit);
               if (rsp_data.allow_hit !== want.allow_hit)
                  report("allow_hit", want.allow_hit, rsp_data.allow_hit);
            end
         end
      end
      pending_verdicts = verdict_q.size();
   end

endmodule

### tb/sv/ip_range_block_allow_lookup_top_tb.sv
// Stimulus and verdict for the IPv4 range lookup block. The checker beside
// the block does all prediction; this module only makes traffic.
module ip_range_block_allow_lookup_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // This pause comfortably covers a load still in flight when the last result
   // has come.
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASE_BEATS   = 75;
   localparam int BLK_FILL      = 128;
   localparam int ALW_FILL      = 32;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_push = 1'b0;
   logic                              req_full;
   irb_pkg::req_type                  req_data = '0;
   logic                              rsp_empty;
   logic                              rsp_pop = 1'b0;
   irb_pkg::rsp_type                  rsp_data;
   logic                              csr_write_en = 1'b0;
   logic [1:0]                        csr_index = irb_pkg::CSR_BLOCK_COUNT;
   logic [irb_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   int pending_verdicts;
   int mismatch_count;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_asked = 0;
   int cycle_count = 0;

   ip_range_block_allow_lookup_top dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   irb_lookup_checker checker_i (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending_verdicts(pending_verdicts), .mismatch_count(mismatch_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver. It pops at random according to recv_idle, and when the
   // stimulus asks for it, it holds off for a long stretch so that the result
   // register and the front queue fill and req_full rises.
   always @(posedge clock) begin
      int hold_seen, hold_left;
      if (reset) begin
         hold_seen = hold_asked;
         hold_left = 0;
         rsp_pop <= 1'b0;
      end else begin
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   function automatic irb_pkg::req_type make_beat(input logic [1:0] cmd,
                                                  input logic [11:0] idx,
                                                  input logic [31:0] lo,
                                                  input logic [31:0] hi,
                                                  input logic [15:0] tag,
                                                  input logic [31:0] addr,
                                                  input logic exempt);
      irb_pkg::req_type b;
      b.cmd           = cmd;
      b.entry_index   = idx;
      b.range_start   = lo;
      b.range_end     = hi;
      b.label_id      = tag;
      b.query_address = addr;
      b.port_allowed  = exempt;
      return b;
   endfunction

   // Offers one beat and returns once it has been taken. push is only
   // lowered when the sender chooses to idle, so back-to-back beats keep it
   // high without a second assignment in the same step.
   task automatic send_beat(input irb_pkg::req_type b);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_full);
   endtask

   // Waits until every query has been answered and the engine has had time
   // to finish a trailing load, so that registers may be written. The first
   // edge lets the checker count a beat taken at the previous edge.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_verdicts != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input int blk, input int alw, input bit http);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= irb_pkg::CSR_BLOCK_COUNT;
      csr_wdata    <= irb_pkg::CSR_DATA_BITS'(blk);
      @(posedge clock);
      csr_index    <= irb_pkg::CSR_ALLOW_COUNT;
      csr_wdata    <= irb_pkg::CSR_DATA_BITS'(alw);
      @(posedge clock);
      csr_index    <= irb_pkg::CSR_BLOCK_HTTP;
      csr_wdata    <= irb_pkg::CSR_DATA_BITS'(http);
      @(posedge clock);
      csr_write_en <= 1'b0;
      csr_wdata    <= '0;
   endtask

   // Block entry i sits in the i-th 1 MiB slice of the address space and
   // allow entry j in the j-th 4 MiB slice, so both tables stay sorted and
   // free of overlaps while the allow ranges cut across block ranges.
   function automatic irb_pkg::req_type block_load(input int i);
      logic [31:0] lo;
      lo = 32'((i << 20) + $urandom_range(0, 'hFFFF));
      return make_beat(irb_pkg::CMD_WRITE_BLOCK, 12'(i), lo,
                       lo + 32'($urandom_range(0, 'h7FFFF)),
                       16'($urandom), $urandom, 1'($urandom_range(1)));
   endfunction

   function automatic irb_pkg::req_type allow_load(input int j);
      logic [31:0] lo;
      lo = 32'((j << 22) + $urandom_range(0, 'h1FFFFF));
      return make_beat(irb_pkg::CMD_WRITE_ALLOW, 12'(j), lo,
                       lo + 32'($urandom_range(0, 'hFFFFF)),
                       16'($urandom), $urandom, 1'($urandom_range(1)));
   endfunction

   // Query addresses lean towards range edges and interiors, where the
   // search has to make its finer decisions.
   function automatic irb_pkg::req_type random_query();
      logic [31:0] addr;
      int          pick;
      pick = $urandom_range(99);
      addr = 32'($urandom_range(0, 255) << 20);
      if (pick < 40) addr = addr + 32'($urandom_range(0, 'h8FFFF));
      else if (pick < 55) addr = addr + 32'($urandom_range(0, 3));
      else if (pick < 70) addr = addr + 32'('hFFFFF - $urandom_range(0, 1));
      else addr = $urandom;
      return make_beat(irb_pkg::CMD_QUERY, 12'($urandom), $urandom, $urandom,
                       16'($urandom), addr, 1'($urandom_range(1)));
   endfunction

   task automatic random_phase(input int beats);
      int pick;
      irb_pkg::req_type b;
      repeat (beats) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            b = random_query();
         end else if (pick < 85) begin
            b = block_load($urandom_range(0, 4095));
         end else if (pick < 95) begin
            // Some allow loads aim past the table and must be ignored.
            b = allow_load($urandom_range(0, 1023));
            if ($urandom_range(3) == 0) b.entry_index = 12'($urandom_range(1024, 4095));
         end else if (pick < 97) begin
            b = make_beat(irb_pkg::CMD_WRITE_BLOCK, 12'($urandom), $urandom, $urandom,
                          16'($urandom), $urandom, 1'($urandom_range(1)));
         end else begin
            b = make_beat(irb_pkg::CMD_RESERVED, 12'($urandom), $urandom, $urandom,
                          16'($urandom), $urandom, 1'($urandom_range(1)));
         end
         send_beat(b);
      end
   endtask

   initial begin
      irb_pkg::req_type b;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats against empty tables: no query may hit, the unknown
      // command does nothing and an allow load beyond the table is dropped.
      send_beat(make_beat(irb_pkg::CMD_QUERY, '0, '0, '0, '0, 32'h0, 1'b0));
      send_beat(make_beat(irb_pkg::CMD_QUERY, '1, '1, '1, '1, 32'hFFFF_FFFF, 1'b1));
      send_beat(make_beat(irb_pkg::CMD_RESERVED, '1, '1, '1, '1, '1, 1'b1));
      send_beat(make_beat(irb_pkg::CMD_WRITE_ALLOW, 12'hFFF, '1, '1, '1, '1, 1'b0));
      send_beat(make_beat(irb_pkg::CMD_QUERY, '0, '0, '0, '0, 32'h0010_0000, 1'b1));

      // Fill the low part of both tables; counts never reach past it. The
      // first block range starts at zero and the last one ends at the top.
      for (int i = 0; i < BLK_FILL; i++) begin
         b = block_load(i);
         if (i == 0) begin
            b.range_start = '0;
            b.label_id    = 16'hFFFF;
         end
         if (i == BLK_FILL - 1) begin
            b.range_end = '1;
            b.label_id  = '0;
         end
         send_beat(b);
      end
      for (int j = 0; j < ALW_FILL; j++) send_beat(allow_load(j));

      // One block range, no allow ranges, exempt ports honoured.
      set_regs(1, 0, 1'b0);
      send_beat(make_beat(irb_pkg::CMD_QUERY, '0, '0, '0, '0, 32'h0, 1'b1));
      send_beat(make_beat(irb_pkg::CMD_QUERY, '0, '0, '0, '0, 32'h0, 1'b0));
      send_beat(make_beat(irb_pkg::CMD_QUERY, '0, '0, '0, '0, 32'hFFFF_FFFF, 1'b0));
      send_beat(make_beat(irb_pkg::CMD_QUERY, '0, '0, '0, '0, 32'h0008_0000, 1'b0));

      // All loaded entries in use, every port checked.
      set_regs(BLK_FILL, ALW_FILL, 1'b1);
      send_beat(make_beat(irb_pkg::CMD_QUERY, '0, '0, '0, '0, 32'hFFFF_FFFF, 1'b1));
      send_beat(make_beat(irb_pkg::CMD_QUERY, '0, '0, '0, '0, 32'h0, 1'b1));
      send_idle = 37;
      recv_idle = 79;
      random_phase(PHASE_BEATS);

      // Shorter tables; exempt ports apply.
      set_regs(BLK_FILL - 28, ALW_FILL - 12, 1'b0);
      send_idle = 79;
      recv_idle = 37;
      random_phase(PHASE_BEATS);

      // Partial tables at full speed, with one long stall of the receiver so
      // that the block backs up into its input.
      set_regs($urandom_range(1, BLK_FILL), $urandom_range(0, ALW_FILL),
               1'($urandom_range(1)));
      send_idle = 0;
      recv_idle = 0;
      hold_asked++;
      random_phase(PHASE_BEATS);

      drain();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
